// File: sv/tccw_pkg.sv
// Shared types, codes and constants of the text console character writer.
// No dependencies; every other file of the block but tccw_ram refers to this package.
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int unsigned CURSOR_W = 11;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned CELL_W   = 16;
  localparam int unsigned COLOR_W  = 4;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned REG_IDX_W = 2;

  localparam int unsigned TAB_STEP = 8;

  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'd0;

  localparam logic [REG_IDX_W-1:0] REG_NORMAL_FG  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ERASE_FG   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BACK_COLOR = 2'd2;

  localparam logic [COLOR_W-1:0] RESET_NORMAL_FG  = 4'd7;
  localparam logic [COLOR_W-1:0] RESET_ERASE_FG   = 4'd15;
  localparam logic [COLOR_W-1:0] RESET_BACK_COLOR = 4'd0;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    OP_PRINT     = 3'd0,
    OP_NEWLINE   = 3'd1,
    OP_RETURN    = 3'd2,
    OP_TAB       = 3'd3,
    OP_BACKSPACE = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_READ      = 3'd6,
    OP_NOP       = 3'd7
  } op_kind_e;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [CHAR_W-1:0]   char_code;
    logic [COLOR_W-1:0]  clear_fg;
    logic [COLOR_W-1:0]  clear_bg;
    logic [INDEX_W-1:0]  cell_index;
  } in_word_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [CELL_W-1:0]   cell_data;
  } out_word_t;

  typedef struct packed {
    op_kind_e            kind;
    logic [CHAR_W-1:0]   char_code;
    logic [COLOR_W-1:0]  clear_fg;
    logic [COLOR_W-1:0]  clear_bg;
    logic [INDEX_W-1:0]  cell_index;
    logic                read_ok;
  } op_t;

  typedef struct packed {
    logic [COLOR_W-1:0] normal_fg;
    logic [COLOR_W-1:0] erase_fg;
    logic [COLOR_W-1:0] back_color;
  } cfg_t;

  function automatic logic [CELL_W-1:0] make_cell(logic [CHAR_W-1:0] ch,
                                                  logic [COLOR_W-1:0] fg,
                                                  logic [COLOR_W-1:0] bg);
    return {bg, fg, ch};
  endfunction

endpackage

// File: sv/text_console_char_writer_unit.sv
// Top level of the text console character writer: configuration registers,
// front end, operation queue and back end. Depends on tccw_pkg and all tccw_ modules.
//
//   Port group          Direction  Handshake            Word
//   in_*                in         in_valid_i/in_ready_o  tccw_pkg::in_word_t
//   out_*               out        out_valid_o/out_ready_i tccw_pkg::out_word_t
//   cfg_*               in         cfg_we_i (no wait)     4-bit register value
//
// A printable character, control code, unused command or out-of-range read
// is handled in idle; a read in range passes S_READ (registered memory port).
// A clear fills every cell in S_CLEAR; a put that scrolls moves the rows up
// in S_COPY and blanks the last row in S_BLANK, via the single memory write port.
// The two-entry queue takes words until full while the back end is busy or
// the output word waits. Reset homes the cursor; screen contents stay undefined.
`timescale 1ns / 1ps

module text_console_char_writer_unit #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  tccw_pkg::in_word_t                   in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output tccw_pkg::out_word_t                  out_word_o,
  input  logic                                 cfg_we_i,
  input  logic [tccw_pkg::REG_IDX_W-1:0]       cfg_index_i,
  input  logic [tccw_pkg::COLOR_W-1:0]         cfg_data_i
);

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned AW        = $clog2(CellCount);

  tccw_pkg::cfg_t cfg_q, cfg_d;
  logic           push_valid, push_ready;
  tccw_pkg::op_t  push_op, pop_op;
  logic           op_valid, op_pop;
  logic           back_busy;
  logic [AW-1:0]  back_pos;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        tccw_pkg::REG_NORMAL_FG:  cfg_d.normal_fg  = cfg_data_i;
        tccw_pkg::REG_ERASE_FG:   cfg_d.erase_fg   = cfg_data_i;
        tccw_pkg::REG_BACK_COLOR: cfg_d.back_color = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_fg  <= tccw_pkg::RESET_NORMAL_FG;
      cfg_q.erase_fg   <= tccw_pkg::RESET_ERASE_FG;
      cfg_q.back_color <= tccw_pkg::RESET_BACK_COLOR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tccw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_op_o   (push_op)
  );

  tccw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_op_i   (push_op),
    .pop_valid_o (op_valid),
    .pop_i       (op_pop),
    .pop_op_o    (pop_op)
  );

  tccw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (op_valid),
    .op_i       (pop_op),
    .op_pop_o   (op_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .busy_o     (back_busy),
    .pos_o      (back_pos)
  );

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(back_pos) < CellCount)
    else $error("cursor left the screen");

  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop |-> op_valid)
    else $error("back end popped an empty queue");

  a_no_pop_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_busy |-> !op_pop)
    else $error("back end took a word while a long operation runs");

  a_busy_holds_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_busy && $past(back_busy)) |-> !$rose(out_valid_o))
    else $error("result appeared in the middle of a long operation");

endmodule

// File: sv/tccw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tccw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tccw_front.sv
// Front end: takes input words and classifies them into screen operations.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_front #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tccw_pkg::in_word_t in_word_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output tccw_pkg::op_t      push_op_o
);

  localparam int unsigned CellCount = COLUMNS * ROWS;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    push_op_o.char_code  = in_word_i.char_code;
    push_op_o.clear_fg   = in_word_i.clear_fg;
    push_op_o.clear_bg   = in_word_i.clear_bg;
    push_op_o.cell_index = in_word_i.cell_index;
    push_op_o.read_ok    = 32'(in_word_i.cell_index) < CellCount;
    unique case (in_word_i.cmd)
      tccw_pkg::CMD_PUT: begin
        unique case (in_word_i.char_code)
          tccw_pkg::CHAR_NEWLINE:   push_op_o.kind = tccw_pkg::OP_NEWLINE;
          tccw_pkg::CHAR_RETURN:    push_op_o.kind = tccw_pkg::OP_RETURN;
          tccw_pkg::CHAR_TAB:       push_op_o.kind = tccw_pkg::OP_TAB;
          tccw_pkg::CHAR_BACKSPACE: push_op_o.kind = tccw_pkg::OP_BACKSPACE;
          default:                  push_op_o.kind = tccw_pkg::OP_PRINT;
        endcase
      end
      tccw_pkg::CMD_CLEAR: push_op_o.kind = tccw_pkg::OP_CLEAR;
      tccw_pkg::CMD_READ:  push_op_o.kind = tccw_pkg::OP_READ;
      default:             push_op_o.kind = tccw_pkg::OP_NOP;
    endcase
  end

endmodule

// File: sv/tccw_queue.sv
// Two-entry operation queue between the front end and the back end.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tccw_pkg::op_t push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output tccw_pkg::op_t pop_op_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tccw_pkg::op_t   slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_op_o     = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// File: sv/tccw_back.sv
// Back end: cursor, screen memory and the sequencer for scroll, clear and read.
// Depends on tccw_pkg and tccw_ram.
`timescale 1ns / 1ps

module tccw_back #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tccw_pkg::cfg_t                       cfg_i,
  input  logic                                 op_valid_i,
  input  tccw_pkg::op_t                        op_i,
  output logic                                 op_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output tccw_pkg::out_word_t                  out_word_o,
  output logic                                 busy_o,
  output logic [$clog2(COLUMNS * ROWS)-1:0]    pos_o
);

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned AW        = $clog2(CellCount);
  localparam int unsigned AWX       = AW + 1;
  localparam int unsigned CW        = $clog2(COLUMNS);
  localparam int unsigned CWX       = CW + 1;
  localparam int unsigned CurW      = tccw_pkg::CURSOR_W;
  localparam int unsigned CellW     = tccw_pkg::CELL_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_COPY  = 5'b00010,
    S_BLANK = 5'b00100,
    S_CLEAR = 5'b01000,
    S_READ  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [CW-1:0]       col_q, col_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic                copy_pend_q, copy_pend_d;
  logic [AW-1:0]       copy_dst_q, copy_dst_d;
  logic [CellW-1:0]    fill_q, fill_d;
  logic                out_valid_q, out_valid_d;
  tccw_pkg::out_word_t out_word_q, out_word_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [CellW-1:0]    ram_wdata, ram_rdata;

  logic [AWX-1:0]      pos_ext, nxt_pos;
  logic [CWX-1:0]      col_ext, col_inc, col_tab;
  logic [CW-1:0]       nxt_col;
  logic                scroll_need, slot_free, pop;
  logic [AW-1:0]       emit_pos;
  logic [CellW-1:0]    emit_data;
  logic                emit;

  tccw_ram #(
    .Width(CellW),
    .Depth(CellCount)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop       = (state_q == S_IDLE) && op_valid_i && slot_free;
  assign pos_ext   = {1'b0, pos_q};
  assign col_ext   = {1'b0, col_q};
  assign col_inc   = col_ext + CWX'(1);
  assign col_tab   = col_ext + CWX'(tccw_pkg::TAB_STEP);

  always_comb begin
    nxt_pos = pos_ext;
    nxt_col = col_q;
    unique case (op_i.kind)
      tccw_pkg::OP_PRINT: begin
        nxt_pos = pos_ext + AWX'(1);
        nxt_col = (col_inc == CWX'(COLUMNS)) ? '0 : col_inc[CW-1:0];
      end
      tccw_pkg::OP_TAB: begin
        nxt_pos = pos_ext + AWX'(tccw_pkg::TAB_STEP);
        nxt_col = (col_tab >= CWX'(COLUMNS)) ? CW'(col_tab - CWX'(COLUMNS))
                                             : col_tab[CW-1:0];
      end
      tccw_pkg::OP_NEWLINE: begin
        nxt_pos = pos_ext - AWX'(col_q) + AWX'(COLUMNS);
        nxt_col = '0;
      end
      tccw_pkg::OP_RETURN: begin
        nxt_pos = pos_ext - AWX'(col_q);
        nxt_col = '0;
      end
      tccw_pkg::OP_BACKSPACE: begin
        if (pos_q != '0) begin
          nxt_pos = pos_ext - AWX'(1);
          nxt_col = (col_q == '0) ? CW'(COLUMNS - 1) : col_q - CW'(1);
        end
      end
      default: begin
        nxt_pos = pos_ext;
        nxt_col = col_q;
      end
    endcase
  end

  assign scroll_need = nxt_pos >= AWX'(CellCount);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    col_d       = col_q;
    idx_d       = idx_q;
    copy_pend_d = 1'b0;
    copy_dst_d  = copy_dst_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = fill_q;
    ram_raddr   = idx_q;
    emit        = 1'b0;
    emit_pos    = pos_q;
    emit_data   = '0;

    if (copy_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = copy_dst_q;
      ram_wdata = ram_rdata;
    end

    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          unique case (op_i.kind)
            tccw_pkg::OP_CLEAR: begin
              pos_d   = '0;
              col_d   = '0;
              idx_d   = '0;
              fill_d  = tccw_pkg::make_cell(tccw_pkg::CHAR_BLANK, op_i.clear_fg,
                                            op_i.clear_bg);
              state_d = S_CLEAR;
            end
            tccw_pkg::OP_READ: begin
              if (op_i.read_ok) begin
                ram_raddr = AW'(op_i.cell_index);
                state_d   = S_READ;
              end else begin
                emit = 1'b1;
              end
            end
            tccw_pkg::OP_NOP: begin
              emit = 1'b1;
            end
            default: begin
              if (op_i.kind == tccw_pkg::OP_PRINT) begin
                ram_we    = 1'b1;
                ram_waddr = pos_q;
                ram_wdata = tccw_pkg::make_cell(op_i.char_code, cfg_i.normal_fg,
                                                cfg_i.back_color);
              end else if (op_i.kind == tccw_pkg::OP_BACKSPACE && pos_q != '0) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(nxt_pos);
                ram_wdata = tccw_pkg::make_cell(tccw_pkg::CHAR_SPACE, cfg_i.erase_fg,
                                                cfg_i.back_color);
              end
              col_d = nxt_col;
              if (scroll_need) begin
                pos_d   = AW'(nxt_pos - AWX'(COLUMNS));
                idx_d   = AW'(COLUMNS);
                fill_d  = tccw_pkg::make_cell(tccw_pkg::CHAR_BLANK, cfg_i.erase_fg,
                                              cfg_i.back_color);
                state_d = S_COPY;
              end else begin
                pos_d    = AW'(nxt_pos);
                emit     = 1'b1;
                emit_pos = AW'(nxt_pos);
              end
            end
          endcase
        end
      end
      S_COPY: begin
        ram_raddr   = idx_q;
        copy_pend_d = 1'b1;
        copy_dst_d  = idx_q - AW'(COLUMNS);
        if (idx_q == AW'(CellCount - 1)) begin
          idx_d   = AW'(CellCount - COLUMNS);
          state_d = S_BLANK;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_BLANK: begin
        if (!copy_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = fill_q;
          if (idx_q == AW'(CellCount - 1)) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = fill_q;
        if (idx_q == AW'(CellCount - 1)) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_READ: begin
        emit      = 1'b1;
        emit_data = ram_rdata;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d          = 1'b1;
      out_word_d.cursor    = CurW'(emit_pos);
      out_word_d.cell_data = emit_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      col_q       <= '0;
      copy_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      col_q       <= col_d;
      copy_pend_q <= copy_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    copy_dst_q <= copy_dst_d;
    fill_q     <= fill_d;
    out_word_q <= out_word_d;
  end

  assign op_pop_o    = pop;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign busy_o      = state_q != S_IDLE;
  assign pos_o       = pos_q;

endmodule
